// ----- design/uid_pkg.sv -----
package uid_pkg;

  localparam int ID_COUNT_DEF = 1024;

  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_RELEASE = 2'd1;
  localparam logic [1:0] MODE_CLEAR   = 2'd2;

endpackage

// ----- design/uid_ram.sv -----
module uid_ram import uid_pkg::*; #(
  parameter int WIDTH = 1,
  parameter int DEPTH = ID_COUNT_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/unique_id_allocator.sv -----
// Release, mode 3 and allocate before the first wrap: the request goes from S_IDLE
// to S_OUT and then into the output register; no new request is taken before that.
// Allocate after the wrap: S_CHK first examines k IDs, with k in 1 .. ID_COUNT-1;
// the bitmap RAM read port limits the search to one ID per cycle.
// Clear: the bitmap is swept one entry per cycle, then the result goes out through S_OUT.
// Reset (synchronous) runs the same sweep over all ID_COUNT entries with s_tready low.
module unique_id_allocator import uid_pkg::*; #(
  parameter int ID_COUNT = ID_COUNT_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // release_id, zero filled to whole bytes
  input  logic [(($clog2(ID_COUNT)+7)/8)*8-1:0]  s_tdata,
  // mode
  input  logic [1:0]                             s_tuser,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // issued_id, zero filled to whole bytes
  output logic [(($clog2(ID_COUNT)+7)/8)*8-1:0]  m_tdata,
  // full_res
  output logic [0:0]                             m_tuser
);

  localparam int ID_W   = $clog2(ID_COUNT);
  localparam int DATA_W = ((ID_W + 7) / 8) * 8;

  localparam logic [ID_W:0]   COUNT_V  = (ID_W+1)'(ID_COUNT);
  localparam logic [ID_W-1:0] TOP_ID   = ID_W'(ID_COUNT - 1);
  localparam logic [ID_W-1:0] CNT_LAST = ID_W'(ID_COUNT - 2);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_OUT  = 3'd3;

  logic [2:0]      state;
  logic [ID_W-1:0] next_id;
  logic            wrapped;
  logic [ID_W-1:0] clr_addr;
  logic            clr_req;
  logic [ID_W-1:0] scan_c;
  logic [ID_W-1:0] scan_cnt;
  logic [ID_W-1:0] res_id;
  logic            res_full;
  logic [ID_W-1:0] out_id;
  logic            out_full;

  logic            accept;
  logic [1:0]      mode;
  logic [ID_W-1:0] rid;
  logic            rid_ok;
  logic [ID_W:0]   n_ext;
  logic            wrap_now;
  logic [ID_W-1:0] n_id;
  logic [ID_W-1:0] scan_adv;

  logic            ram_we;
  logic [ID_W-1:0] ram_waddr;
  logic            ram_wdata;
  logic [ID_W-1:0] ram_raddr;
  logic            ram_rdata;

  function automatic logic [ID_W-1:0] advance(input logic [ID_W-1:0] v);
    logic [ID_W-1:0] r;
    if (v == TOP_ID) begin
      r = ID_W'(1);
    end else begin
      r = v + ID_W'(1);
    end
    return r;
  endfunction

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign mode     = s_tuser;
  assign rid      = s_tdata[ID_W-1:0];
  assign rid_ok   = (rid != '0) && ({1'b0, rid} < COUNT_V);
  assign n_ext    = {1'b0, next_id} + (ID_W+1)'(1);
  assign wrap_now = (n_ext >= COUNT_V);
  assign n_id     = wrap_now ? ID_W'(1) : n_ext[ID_W-1:0];
  assign scan_adv = advance(scan_c);

  assign m_tdata = DATA_W'(out_id);
  assign m_tuser = out_full;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = 1'b0;
    ram_raddr = scan_adv;
    case (state)
      S_CLR: begin
        ram_we = 1'b1;
      end
      S_IDLE: begin
        ram_raddr = n_id;
        if (accept && mode == MODE_ALLOC && !wrap_now && !wrapped) begin
          ram_we    = 1'b1;
          ram_waddr = n_id;
          ram_wdata = 1'b1;
        end else if (accept && mode == MODE_RELEASE && rid_ok) begin
          ram_we    = 1'b1;
          ram_waddr = rid;
        end
      end
      S_CHK: begin
        if (!ram_rdata) begin
          ram_we    = 1'b1;
          ram_waddr = scan_c;
          ram_wdata = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  uid_ram #(
    .WIDTH (1),
    .DEPTH (ID_COUNT)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      next_id  <= '0;
      wrapped  <= 1'b0;
      clr_addr <= '0;
      clr_req  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // S_OUT loads the output register; otherwise it empties once the result is taken.
      if (state == S_OUT) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + ID_W'(1);
          if (clr_addr == TOP_ID) begin
            state <= clr_req ? S_OUT : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            res_full <= 1'b0;
            case (mode)
              MODE_ALLOC: begin
                next_id <= n_id;
                if (wrap_now || wrapped) begin
                  // Search the bitmap from the advanced counter, one ID per cycle.
                  wrapped  <= 1'b1;
                  scan_c   <= n_id;
                  scan_cnt <= '0;
                  res_id   <= '0;
                  state    <= S_CHK;
                end else begin
                  res_id <= n_id;
                  state  <= S_OUT;
                end
              end
              MODE_CLEAR: begin
                next_id  <= '0;
                clr_addr <= '0;
                clr_req  <= 1'b1;
                res_id   <= '0;
                state    <= S_CLR;
              end
              default: begin
                res_id <= '0;
                state  <= S_OUT;
              end
            endcase
          end
        end
        S_CHK: begin
          if (!ram_rdata) begin
            next_id <= scan_c;
            res_id  <= scan_c;
            state   <= S_OUT;
          end else if (scan_cnt == CNT_LAST) begin
            // Every ID from 1 to ID_COUNT-1 has been examined and all are taken.
            res_full <= 1'b1;
            state    <= S_OUT;
          end else begin
            scan_c   <= scan_adv;
            scan_cnt <= scan_cnt + ID_W'(1);
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            out_id   <= res_id;
            out_full <= res_full;
            clr_req  <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_full_gives_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("full result carries a non-zero ID");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken before the first was finished");

  a_search_after_wrap: assert property (@(posedge clk) disable iff (rst)
    state == S_CHK |-> wrapped)
    else $error("bitmap search started before the counter wrapped");

  a_id_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> {1'b0, m_tdata[ID_W-1:0]} < COUNT_V)
    else $error("issued ID out of range");

endmodule
